// File: design/xyzma_pkg.sv
// shared types and constants for the three-axis moving average
package xyzma_pkg;

   localparam int SAMPLE_W = 16;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_x;
      logic signed [SAMPLE_W-1:0] sample_y;
      logic signed [SAMPLE_W-1:0] sample_z;
      logic                       sample_ok;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mean_x;
      logic signed [SAMPLE_W-1:0] mean_y;
      logic signed [SAMPLE_W-1:0] mean_z;
      logic                       all_ok;
      logic                       window_full;
   } rsp_type;

   typedef struct packed {
      logic accept;     // capture the incoming item
      logic read;       // read the slot about to be reused
      logic update;     // update sums, counts and the window
      logic div_init;   // load the dividers
      logic div_step;   // one quotient bit per axis
      logic load_out;   // move the means to the output register
   } cmd_type;

   typedef struct packed {
      logic div_done;   // last divider step in progress
      logic out_free;   // output register can take a new item
   } sts_type;

endpackage

// File: design/xyzma_ctrl.sv
// sequencer for one item: read, update, divide, hand off
module xyzma_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  xyzma_pkg::sts_type sts,
   output xyzma_pkg::cmd_type cmd
);
   import xyzma_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_UPDATE = 3'd2;
   localparam logic [2:0] S_INIT   = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_INIT;
         end
         S_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/xyzma_dp.sv
// window store, running sums, bit-serial dividers and output register
module xyzma_dp #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  xyzma_pkg::req_type req_data,
   input  xyzma_pkg::cmd_type cmd,
   output xyzma_pkg::sts_type sts,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output xyzma_pkg::rsp_type rsp_data
);
   import xyzma_pkg::*;

   localparam int SLW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int SW  = SAMPLE_W + $clog2(DEPTH);
   localparam int STW = $clog2(SW);
   localparam int EXT = SW - SAMPLE_W;

   req_type              mem [DEPTH];
   req_type              in_ff;
   req_type              old_ff;

   logic signed [SW-1:0] sum_ff [3];
   logic signed [SW-1:0] sum_in [3];
   logic [CW-1:0]        fill_ff;
   logic [CW-1:0]        fill_in;
   logic [CW-1:0]        bad_ff;
   logic [CW-1:0]        bad_in;
   logic [SLW-1:0]       slot_ff;
   logic [SLW-1:0]       slot_in;
   logic                 full;

   logic [SW-1:0]        quo_ff [3];
   logic [SW-1:0]        quo_in [3];
   logic [CW-1:0]        rem_ff [3];
   logic [CW-1:0]        rem_in [3];
   logic                 neg_ff [3];
   logic [STW-1:0]       step_ff;
   logic [SAMPLE_W-1:0]  mean [3];

   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic signed [SAMPLE_W-1:0] new_v [3];
   logic signed [SAMPLE_W-1:0] old_v [3];

   assign new_v[0] = in_ff.sample_x;
   assign new_v[1] = in_ff.sample_y;
   assign new_v[2] = in_ff.sample_z;
   assign old_v[0] = old_ff.sample_x;
   assign old_v[1] = old_ff.sample_y;
   assign old_v[2] = old_ff.sample_z;

   assign full = (fill_ff == CW'(DEPTH));

   // window update: evict the oldest entry once full
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sum_in[a] = sum_ff[a] + {{EXT{new_v[a][SAMPLE_W-1]}}, new_v[a]};
         if (full) begin
            sum_in[a] = sum_in[a] - {{EXT{old_v[a][SAMPLE_W-1]}}, old_v[a]};
         end
      end
      fill_in = full ? fill_ff : fill_ff + 1'b1;
      bad_in  = bad_ff;
      if (full && !old_ff.sample_ok && (bad_ff != '0)) begin
         bad_in = bad_in - 1'b1;
      end
      if (!in_ff.sample_ok) begin
         bad_in = bad_in + 1'b1;
      end
      slot_in = (slot_ff == SLW'(DEPTH - 1)) ? '0 : slot_ff + 1'b1;
   end

   // restoring division of the magnitude, one bit per step
   always_comb begin
      logic [CW:0] trial;
      for (int a = 0; a < 3; a++) begin
         trial = {rem_ff[a], quo_ff[a][SW-1]};
         if (trial >= {1'b0, fill_ff}) begin
            rem_in[a] = CW'(trial - {1'b0, fill_ff});
            quo_in[a] = {quo_ff[a][SW-2:0], 1'b1};
         end else begin
            rem_in[a] = trial[CW-1:0];
            quo_in[a] = {quo_ff[a][SW-2:0], 1'b0};
         end
         mean[a] = neg_ff[a] ? SAMPLE_W'(-quo_ff[a][SAMPLE_W-1:0])
                             : quo_ff[a][SAMPLE_W-1:0];
      end
   end

   assign sts.div_done = (step_ff == STW'(SW - 1));
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         in_ff <= req_data;
      end
      if (cmd.read) begin
         old_ff <= mem[slot_ff];
      end
      if (cmd.update) begin
         mem[slot_ff] <= in_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            sum_ff[a] <= '0;
         end
         fill_ff <= '0;
         bad_ff  <= '0;
         slot_ff <= '0;
      end else if (cmd.update) begin
         for (int a = 0; a < 3; a++) begin
            sum_ff[a] <= sum_in[a];
         end
         fill_ff <= fill_in;
         bad_ff  <= bad_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         for (int a = 0; a < 3; a++) begin
            neg_ff[a] <= sum_ff[a][SW-1];
            quo_ff[a] <= sum_ff[a][SW-1] ? SW'(-sum_ff[a]) : sum_ff[a];
            rem_ff[a] <= '0;
         end
         step_ff <= '0;
      end else if (cmd.div_step) begin
         for (int a = 0; a < 3; a++) begin
            quo_ff[a] <= quo_in[a];
            rem_ff[a] <= rem_in[a];
         end
         step_ff <= step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff.mean_x      <= mean[0];
         rsp_ff.mean_y      <= mean[1];
         rsp_ff.mean_z      <= mean[2];
         rsp_ff.all_ok      <= (bad_ff == '0);
         rsp_ff.window_full <= full;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/xyz_moving_average.sv
// top level of the three-axis sliding-window average
//
// req_valid/req_stall/req_data carry one sample item (x, y, z, ok bit);
// an item is taken on an edge with valid high and stall low.
// rsp_valid/rsp_stall/rsp_data return one item per sample: the window
// means of each axis, truncated toward zero, plus all_ok and window_full.
// Each item goes through the window read, the sum update, a divider load,
// then a bit-serial divider that produces one quotient bit per cycle for
// all three axes at once. The next item can be taken in the cycle after
// the hand-off, so no new item is accepted before the last is handed off.
// The output register holds a result while rsp_stall is high; the next
// sample is accepted meanwhile, and only its hand-off waits for the
// register to drain.
// Reset clears sums, fill and invalid counts, the write slot and the
// output valid; the window memory is not cleared, since its entries are only
// used once every entry has been written.
module xyz_moving_average #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  xyzma_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output xyzma_pkg::rsp_type rsp_data
);
   import xyzma_pkg::*;

   cmd_type cmd;
   sts_type sts;

   xyzma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   xyzma_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
